>>> rtl/fcd_pkg.sv
// fcd_pkg: shared types and constants of the correlation fir with decimation
// no dependencies
`default_nettype none

package fcd_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 16;
    localparam int COEF_IDX_W = 4;
    localparam int TAP_CNT_W  = 5;
    localparam int DECIM_W    = 2;
    localparam int SHIFT_W    = 5;
    localparam int ACC_W      = 40;
    localparam int IDX_W      = 32;
    localparam int REQ_W      = 2;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 5;

    localparam logic [REQ_W-1:0] REQ_SAMPLE  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_COEF    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_RESTART = 2'd2;

    localparam logic [CFG_ADDR_W-1:0] CFG_TAP_COUNT  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_DECIMATION = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_OUT_SHIFT  = 2'd2;

    localparam logic [DECIM_W-1:0] DECIM_BY_TWO = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_ROUND,
        ST_EMIT
    } t_state;

endpackage

`default_nettype wire

>>> rtl/fir_correlate_decimate_unit.sv
// fir_correlate_decimate_unit: correlation fir, optional decimation by two
// one shared multiply-accumulate unit under a small sequencer; uses fcd_pkg
//
// channel   dir  tdata (low bit up)                              tuser
// s_axis    in   sample_value[15:0] coef_index[19:16]            req_type[1:0]
//                coef_value[35:20] zero[39:36]
// m_axis    out  filtered_value[15:0] output_index[47:16]        saturated[0]
// cfg       in   i_cfg_wr_en, i_cfg_addr (register), i_cfg_wdata
//
// a sample that completes a kept window is accepted, then runs one mac per tap,
// a round step and an emit step that waits while the output register is full and not
// taken; other beats skip the mac loop; s_axis_tready is high only when idle
// a finished result waits in the output register while the next beat is taken
// reset is synchronous, active low, and clears counters, coefficients and delay line
`default_nettype none

module fir_correlate_decimate_unit
    import fcd_pkg::*;
#(
    parameter int TAPS = 16
) (
    input  wire  logic                  i_clk,
    input  wire  logic                  i_rst_n,
    input  wire  logic                  s_axis_tvalid,
    output logic                        s_axis_tready,
    // sample_value, coef_index, coef_value, zero pad
    input  wire  logic [39:0]           s_axis_tdata,
    // req_type
    input  wire  logic [REQ_W-1:0]      s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  wire  logic                  m_axis_tready,
    // filtered_value, output_index
    output logic [47:0]                 m_axis_tdata,
    // saturated
    output logic [0:0]                  m_axis_tuser,
    input  wire  logic                  i_cfg_wr_en,
    input  wire  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int MAX_TAPS   = (1 << TAP_CNT_W) - 1;
    localparam int DLY_DEPTH  = (TAPS < MAX_TAPS) ? TAPS : MAX_TAPS;
    localparam int COEF_NUM   = 1 << COEF_IDX_W;
    localparam int COEF_DEPTH = (TAPS < COEF_NUM) ? TAPS : COEF_NUM;
    localparam int DLY_AW     = (DLY_DEPTH > 1) ? $clog2(DLY_DEPTH) : 1;
    localparam int COEF_AW    = (COEF_DEPTH > 1) ? $clog2(COEF_DEPTH) : 1;
    localparam logic [TAP_CNT_W-1:0] TAPS_LIM = TAP_CNT_W'(DLY_DEPTH);

    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] SAT_LO = -ACC_W'(32768);

    t_state r_state, n_state;

    logic [TAP_CNT_W-1:0] r_tap_count;
    logic [DECIM_W-1:0]   r_decimation;
    logic [SHIFT_W-1:0]   r_out_shift;

    logic signed [SAMPLE_W-1:0] r_dly  [DLY_DEPTH];
    logic signed [COEF_W-1:0]   r_coef [COEF_DEPTH];

    logic [TAP_CNT_W-1:0] r_held;
    logic                 r_parity;
    logic [IDX_W-1:0]     r_out_cnt;
    logic [TAP_CNT_W-1:0] r_k;
    logic signed [ACC_W-1:0] r_acc;

    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_value;
    logic                       r_out_sat;
    logic [IDX_W-1:0]           r_out_idx;

    // input fields
    logic [REQ_W-1:0]           in_req;
    logic signed [SAMPLE_W-1:0] in_sample;
    logic [COEF_IDX_W-1:0]      in_coef_idx;
    logic signed [COEF_W-1:0]   in_coef;

    assign in_req      = s_axis_tuser;
    assign in_sample   = s_axis_tdata[15:0];
    assign in_coef_idx = s_axis_tdata[19:16];
    assign in_coef     = s_axis_tdata[35:20];

    logic [TAP_CNT_W-1:0] taps;
    logic [TAP_CNT_W-1:0] n_held;
    logic                 in_beat;
    logic                 is_sample;
    logic                 window_done;
    logic                 keep;
    logic                 start_mac;
    logic                 mac_last;
    logic                 emit_load;
    logic [TAP_CNT_W-1:0] dly_idx;
    logic signed [SAMPLE_W-1:0] dly_rd;
    logic signed [COEF_W-1:0]   coef_rd;
    logic signed [SAMPLE_W+COEF_W-1:0] prod;
    logic signed [ACC_W-1:0] half;
    logic signed [ACC_W-1:0] shifted;

    always_comb begin
        if (r_tap_count == '0) begin
            taps = TAP_CNT_W'(1);
        end else if (r_tap_count > TAPS_LIM) begin
            taps = TAPS_LIM;
        end else begin
            taps = r_tap_count;
        end
    end

    assign is_sample   = (in_req == REQ_SAMPLE);
    assign n_held      = (r_held < taps) ? r_held + TAP_CNT_W'(1) : r_held;
    assign window_done = !(n_held < taps);
    assign keep        = !((r_decimation == DECIM_BY_TWO) && r_parity);
    assign start_mac   = in_beat && is_sample && window_done && keep;
    assign mac_last    = (r_k == taps - TAP_CNT_W'(1));

    // shared mac operands
    assign dly_idx = taps - TAP_CNT_W'(1) - r_k;
    assign dly_rd  = r_dly[dly_idx[DLY_AW-1:0]];
    assign coef_rd = (32'(r_k) < COEF_DEPTH) ? r_coef[r_k[COEF_AW-1:0]] : '0;
    assign prod    = dly_rd * coef_rd;

    assign half    = (r_out_shift == '0) ? '0
                   : ACC_W'(1) <<< (r_out_shift - SHIFT_W'(1));
    assign shifted = r_acc >>> r_out_shift;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (start_mac) n_state = ST_MAC;
            ST_MAC:   if (mac_last) n_state = ST_ROUND;
            ST_ROUND: n_state = ST_EMIT;
            ST_EMIT:  if (emit_load) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_axis_tready = 1'b0;
        emit_load     = 1'b0;
        case (r_state)
            ST_IDLE:  s_axis_tready = i_rst_n;
            ST_EMIT:  emit_load     = !r_out_valid || m_axis_tready;
            default: begin
                s_axis_tready = 1'b0;
                emit_load     = 1'b0;
            end
        endcase
    end

    assign in_beat = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_tap_count  <= TAP_CNT_W'(16);
            r_decimation <= DECIM_W'(1);
            r_out_shift  <= SHIFT_W'(15);
            r_held       <= '0;
            r_parity     <= 1'b0;
            r_out_cnt    <= '0;
            r_k          <= '0;
            r_out_valid  <= 1'b0;
            for (int i = 0; i < DLY_DEPTH; i++) r_dly[i] <= '0;
            for (int i = 0; i < COEF_DEPTH; i++) r_coef[i] <= '0;
        end else begin
            r_state <= n_state;

            if (i_cfg_wr_en) begin
                case (i_cfg_addr)
                    CFG_TAP_COUNT:  r_tap_count  <= i_cfg_wdata;
                    CFG_DECIMATION: r_decimation <= i_cfg_wdata[DECIM_W-1:0];
                    CFG_OUT_SHIFT:  r_out_shift  <= i_cfg_wdata;
                    default: ;
                endcase
            end

            if (in_beat) begin
                case (in_req)
                    REQ_SAMPLE: begin
                        for (int i = DLY_DEPTH - 1; i > 0; i--) r_dly[i] <= r_dly[i-1];
                        r_dly[0] <= in_sample;
                        r_held   <= n_held;
                        if (window_done) r_parity <= !r_parity;
                    end
                    REQ_COEF: begin
                        if (32'(in_coef_idx) < COEF_DEPTH) begin
                            r_coef[in_coef_idx[COEF_AW-1:0]] <= in_coef;
                        end
                    end
                    REQ_RESTART: begin
                        r_held    <= '0;
                        r_parity  <= 1'b0;
                        r_out_cnt <= '0;
                    end
                    default: ;
                endcase
            end

            if (start_mac) r_k <= '0;
            else if (r_state == ST_MAC) r_k <= r_k + TAP_CNT_W'(1);

            if (emit_load) begin
                r_out_valid <= 1'b1;
                r_out_cnt   <= r_out_cnt + IDX_W'(1);
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // accumulator and result register
    always_ff @(posedge i_clk) begin
        if (start_mac) begin
            r_acc <= '0;
        end else if (r_state == ST_MAC) begin
            r_acc <= r_acc + {{(ACC_W-SAMPLE_W-COEF_W){prod[SAMPLE_W+COEF_W-1]}}, prod};
        end else if (r_state == ST_ROUND) begin
            r_acc <= r_acc + half;
        end

        if (emit_load) begin
            r_out_idx <= r_out_cnt;
            if (shifted > SAT_HI) begin
                r_out_value <= 16'sh7fff;
                r_out_sat   <= 1'b1;
            end else if (shifted < SAT_LO) begin
                r_out_value <= 16'sh8000;
                r_out_sat   <= 1'b1;
            end else begin
                r_out_value <= shifted[SAMPLE_W-1:0];
                r_out_sat   <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_idx, r_out_value};
    assign m_axis_tuser  = r_out_sat;

endmodule

`default_nettype wire

>>> sim/testbench.sv
// testbench for fir_correlate_decimate_unit: directed and random streams of samples,
// coefficient writes and restarts, checked against a built-in window predictor
// depends on rtl/fcd_pkg.sv and rtl/fir_correlate_decimate_unit.sv
`timescale 1ns / 100ps

module testbench;
    import fcd_pkg::*;

    localparam int TAPS          = 16;
    localparam int SETTLE_CYCLES = TAPS + 8;

    localparam logic [REQ_W-1:0]      REQ_UNUSED  = 2'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_UNUSED  = 2'd3;
    localparam logic [DECIM_W-1:0]    DECIM_EVERY = 2'd1;

    typedef struct packed {
        logic signed [15:0] value;
        logic               sat;
        logic [31:0]        index;
    } t_window_out;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // sample_value, coef_index, coef_value, zero pad
    logic [39:0]           s_axis_tdata  = '0;
    // req_type
    logic [REQ_W-1:0]      s_axis_tuser  = REQ_SAMPLE;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // filtered_value, output_index
    logic [47:0]           m_axis_tdata;
    // saturated
    logic [0:0]            m_axis_tuser;
    logic                  i_cfg_wr_en   = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr    = CFG_TAP_COUNT;
    logic [CFG_DATA_W-1:0] i_cfg_wdata   = '0;

    // predictor state
    logic [TAP_CNT_W-1:0] cfg_taps  = 5'd16;
    logic [DECIM_W-1:0]   cfg_decim = DECIM_EVERY;
    logic [SHIFT_W-1:0]   cfg_shift = 5'd15;
    logic signed [15:0]   sample_hist [TAPS];
    logic signed [15:0]   coef_bank [TAPS];
    int                   fill_count  = 0;
    logic                 skip_phase  = 1'b0;
    logic [31:0]          out_count   = '0;

    t_window_out expected_windows [$];
    int          errors  = 0;
    bit          no_idle = 1'b0;

    fir_correlate_decimate_unit #(
        .TAPS(TAPS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata)
    );

    always #2 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        m_axis_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 33);
    end

    function automatic void predict_window(input logic [REQ_W-1:0] req,
                                           input logic signed [15:0] smp,
                                           input logic [3:0] idx,
                                           input logic signed [15:0] coef);
        int          taps;
        int          k;
        longint      acc;
        longint      r;
        logic        keep;
        t_window_out o;
        case (req)
            REQ_COEF: begin
                coef_bank[idx] = coef;
            end
            REQ_RESTART: begin
                fill_count = 0;
                skip_phase = 1'b0;
                out_count  = '0;
            end
            REQ_SAMPLE: begin
                for (k = TAPS - 1; k > 0; k--) sample_hist[k] = sample_hist[k-1];
                sample_hist[0] = smp;
                taps = int'(cfg_taps);
                if (taps < 1) taps = 1;
                if (taps > TAPS) taps = TAPS;
                if (fill_count < taps) fill_count++;
                if (fill_count >= taps) begin
                    keep = !(cfg_decim == DECIM_BY_TWO && skip_phase);
                    skip_phase = ~skip_phase;
                    if (keep) begin
                        acc = 0;
                        for (k = 0; k < taps; k++)
                            acc += longint'(sample_hist[taps-1-k]) * longint'(coef_bank[k]);
                        r = acc + ((cfg_shift != 0) ? (longint'(1) <<< (cfg_shift - 1)) : 0);
                        r = r >>> cfg_shift;
                        o.sat = 1'b0;
                        if (r > 32767) begin
                            r     = 32767;
                            o.sat = 1'b1;
                        end else if (r < -32768) begin
                            r     = -32768;
                            o.sat = 1'b1;
                        end
                        o.value = r[15:0];
                        o.index = out_count;
                        out_count++;
                        expected_windows.push_back(o);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // result check
    always @(posedge i_clk) begin
        t_window_out want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_windows.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected beat: value %0d sat %0d index %0d",
                             $signed(m_axis_tdata[15:0]), m_axis_tuser[0], m_axis_tdata[47:16]);
            end else begin
                want = expected_windows.pop_front();
                if (m_axis_tdata[15:0] !== want.value || m_axis_tuser[0] !== want.sat ||
                    m_axis_tdata[47:16] !== want.index) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: expected value %0d sat %0d index %0d, got %0d %0d %0d",
                                 want.value, want.sat, want.index, $signed(m_axis_tdata[15:0]),
                                 m_axis_tuser[0], m_axis_tdata[47:16]);
                end
            end
        end
    end

    function automatic logic [15:0] pick_q15();
        case ($urandom_range(9))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_beat(input logic [REQ_W-1:0] req, input logic [15:0] smp,
                             input logic [3:0] idx, input logic [15:0] coef);
        int gap;
        if (!no_idle && $urandom_range(99) < 33) begin
            gap = $urandom_range(1, 4);
            repeat (gap) begin
                @(negedge i_clk);
                s_axis_tvalid <= 1'b0;
            end
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0000, coef, idx, smp};
        s_axis_tuser  <= req;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_window(req, smp, idx, coef);
    endtask

    task automatic settle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (expected_windows.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input int data);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= CFG_DATA_W'(data);
        @(posedge i_clk);
        case (addr)
            CFG_TAP_COUNT:  cfg_taps  = TAP_CNT_W'(data);
            CFG_DECIMATION: cfg_decim = DECIM_W'(data);
            CFG_OUT_SHIFT:  cfg_shift = SHIFT_W'(data);
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic set_filter(input int taps, input int decim, input int shift);
        settle();
        write_reg(CFG_TAP_COUNT, taps);
        write_reg(CFG_DECIMATION, decim);
        write_reg(CFG_OUT_SHIFT, shift);
    endtask

    task automatic send_random(input int count);
        int n;
        int pick;
        for (n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 76)
                send_beat(REQ_SAMPLE, pick_q15(), 4'($urandom_range(15)), 16'($urandom));
            else if (pick < 90)
                send_beat(REQ_COEF, 16'($urandom), 4'($urandom_range(15)), pick_q15());
            else if (pick < 95)
                send_beat(REQ_RESTART, 16'($urandom), 4'($urandom_range(15)), 16'($urandom));
            else
                send_beat(REQ_UNUSED, 16'($urandom), 4'($urandom_range(15)), 16'($urandom));
        end
    endtask

    task automatic test_directed();
        set_filter(3, DECIM_EVERY, 15);
        send_beat(REQ_COEF, 16'h0000, 4'd0, 16'h7fff);
        send_beat(REQ_COEF, 16'h0000, 4'd1, 16'h8000);
        send_beat(REQ_COEF, 16'h0000, 4'd2, 16'hffff);
        send_beat(REQ_COEF, 16'h0000, 4'd15, 16'h3039);
        send_beat(REQ_SAMPLE, 16'h7fff, 4'd0, 16'h0000);
        send_beat(REQ_SAMPLE, 16'h8000, 4'd0, 16'h0000);
        send_beat(REQ_SAMPLE, 16'hffff, 4'd0, 16'h0000);
        send_beat(REQ_SAMPLE, 16'h0000, 4'd0, 16'h0000);
        send_beat(REQ_SAMPLE, 16'h0001, 4'd0, 16'h0000);
        // unknown request with every sample, index and coefficient bit set is dropped
        send_beat(REQ_UNUSED, 16'hffff, 4'hf, 16'hffff);
        send_beat(REQ_RESTART, 16'h0000, 4'd0, 16'h0000);
        repeat (3) send_beat(REQ_SAMPLE, 16'h7fff, 4'd0, 16'h0000);
        // no shift, decimate: saturation and skipped windows
        set_filter(3, DECIM_BY_TWO, 0);
        send_beat(REQ_SAMPLE, 16'h8000, 4'd0, 16'h0000);
        send_beat(REQ_SAMPLE, 16'h8000, 4'd0, 16'h0000);
        send_beat(REQ_SAMPLE, 16'h7fff, 4'd0, 16'h0000);
        send_beat(REQ_SAMPLE, 16'h0001, 4'd0, 16'h0000);
        // larger tap count mid-stream waits, smaller one fires at once
        set_filter(5, DECIM_EVERY, 31);
        send_beat(REQ_SAMPLE, 16'h1234, 4'd0, 16'h0000);
        send_beat(REQ_SAMPLE, 16'h8765, 4'd0, 16'h0000);
        set_filter(2, DECIM_EVERY, 15);
        send_beat(REQ_SAMPLE, 16'h4000, 4'd0, 16'h0000);
    endtask

    task automatic test_tap_extremes();
        int tap_list [4];
        int i;
        tap_list = '{0, 1, 16, 31};
        for (i = 0; i < 4; i++) begin
            set_filter(tap_list[i], DECIM_EVERY, $urandom_range(12, 18));
            send_random(40);
        end
    endtask

    task automatic test_decimation();
        int d;
        for (d = 0; d < 4; d++) begin
            set_filter($urandom_range(1, 6), d, 15);
            send_random(50);
        end
    endtask

    task automatic test_shift_sweep();
        int shift_list [3];
        int i;
        shift_list = '{0, 31, $urandom_range(1, 30)};
        for (i = 0; i < 3; i++) begin
            set_filter($urandom_range(1, 16), $urandom_range(0, 3), shift_list[i]);
            send_random(50);
        end
    endtask

    task automatic test_back_to_back();
        no_idle = 1'b1;
        set_filter(8, DECIM_EVERY, 14);
        send_random(80);
        settle();
        send_random(70);
        no_idle = 1'b0;
    endtask

    task automatic test_random_mix();
        int p;
        settle();
        write_reg(CFG_UNUSED, $urandom_range(0, 31));
        for (p = 0; p < 5; p++) begin
            set_filter($urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 31));
            send_random(50);
        end
    endtask

    initial begin
        foreach (sample_hist[i]) sample_hist[i] = '0;
        foreach (coef_bank[i]) coef_bank[i] = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_tap_extremes();
        test_decimation();
        test_shift_sweep();
        test_back_to_back();
        test_random_mix();
        settle();
        if (errors == 0 && expected_windows.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

endmodule

>>> fir_correlate_decimate_unit.f
rtl/fcd_pkg.sv
rtl/fir_correlate_decimate_unit.sv
sim/testbench.sv
